// File: rtl/decimal_digit_calculator_alu_core_macros.svh
// Assertion macros for the calculator RTL
`ifndef DECIMAL_DIGIT_CALCULATOR_ALU_CORE_MACROS_SVH
`define DECIMAL_DIGIT_CALCULATOR_ALU_CORE_MACROS_SVH

// checked only outside reset
`define DDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define DDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/ddcalu_pkg.sv
// Types, constants and helper functions of the decimal calculator ALU
package ddcalu_pkg;

    localparam int NUM_POS = 8;   // digit positions in a beat
    localparam int OPD_W   = 28;  // operand value: 15 * 11111111 fits
    localparam int VAL_W   = 27;  // shown value: at most 99999999
    localparam int RAW_W   = 2 * OPD_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] a_digits;
        logic [7:0]  a_present;
        logic [31:0] b_digits;
        logic [7:0]  b_present;
    } in_t;

    typedef struct packed {
        logic [31:0] answer_digits;
        logic [7:0]  answer_present;
        logic        error;
    } out_t;

    // data riding alongside the divider
    typedef struct packed {
        logic             is_div;
        logic             b_zero;
        logic             bad;
        logic [VAL_W-1:0] value;
    } side_t;

    function automatic logic [OPD_W-1:0] pow10(input int n);
        logic [OPD_W-1:0] p;
        p = OPD_W'(1);
        for (int i = 0; i < NUM_POS; i++) begin
            if (i < n) begin
                p = OPD_W'(p * OPD_W'(10));
            end
        end
        return p;
    endfunction

    function automatic longint unsigned disp_limit(input int digits,
                                                   input longint unsigned maxv);
        longint unsigned top;
        top = 1;
        for (int i = 0; i < NUM_POS; i++) begin
            if (i < digits) begin
                top = top * 10;
            end
        end
        top = top - 1;
        if (maxv < top) begin
            top = maxv;
        end
        return top;
    endfunction

endpackage

// File: rtl/ddcalu_div.sv
// Pipelined restoring divider, one quotient bit per stage
module ddcalu_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [ddcalu_pkg::OPD_W-1:0]  in_dividend,
    input  logic [ddcalu_pkg::OPD_W-1:0]  in_divisor,
    input  ddcalu_pkg::side_t             in_side,
    output logic                          out_vld,
    output logic [ddcalu_pkg::OPD_W-1:0]  out_quo,
    output ddcalu_pkg::side_t             out_side
);
    localparam int W = ddcalu_pkg::OPD_W;

    logic [W:0]   vld_st;
    logic [W-1:0] rem_st [0:W];
    logic [W-1:0] dq_st  [0:W];  // dividend shifts out, quotient shifts in
    logic [W-1:0] dvs_st [0:W];
    ddcalu_pkg::side_t side_st [0:W];

    logic [W:1]   vld_reg;
    logic [W-1:0] rem_reg  [1:W];
    logic [W-1:0] dq_reg   [1:W];
    logic [W-1:0] dvs_reg  [1:W];
    ddcalu_pkg::side_t side_reg [1:W];

    assign vld_st[0]  = in_vld;
    assign rem_st[0]  = '0;
    assign dq_st[0]   = in_dividend;
    assign dvs_st[0]  = in_divisor;
    assign side_st[0] = in_side;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0]   trial;
        logic         qbit;
        logic [W-1:0] rem_next;

        always_comb begin
            trial    = {rem_st[k], dq_st[k][W-1]};
            qbit     = (trial >= {1'b0, dvs_st[k]});
            rem_next = qbit ? W'(trial - {1'b0, dvs_st[k]}) : W'(trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_st[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                dq_reg[k+1]   <= {dq_st[k][W-2:0], qbit};
                dvs_reg[k+1]  <= dvs_st[k];
                side_reg[k+1] <= side_st[k];
            end
        end

        assign vld_st[k+1]  = vld_reg[k+1];
        assign rem_st[k+1]  = rem_reg[k+1];
        assign dq_st[k+1]   = dq_reg[k+1];
        assign dvs_st[k+1]  = dvs_reg[k+1];
        assign side_st[k+1] = side_reg[k+1];
    end

    assign out_vld  = vld_st[W];
    assign out_quo  = dq_st[W];
    assign out_side = side_st[W];

endmodule

// File: rtl/ddcalu_bcd.sv
// Pipelined binary to decimal conversion, one digit per stage
module ddcalu_bcd #(
    parameter logic [31:0] ERR_DIGITS  = 32'h0000_0E0F,
    parameter logic [7:0]  ERR_PRESENT = 8'h07
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic                          in_bad,
    input  logic [ddcalu_pkg::VAL_W-1:0]  in_value,
    output logic                          out_vld,
    output ddcalu_pkg::out_t              out_data
);
    localparam int N = ddcalu_pkg::NUM_POS;
    localparam int V = ddcalu_pkg::VAL_W;

    logic [N:0]    vld_st;
    logic [N:0]    bad_st;
    logic [V-1:0]  val_st  [0:N];
    logic [31:0]   dig_st  [0:N];
    logic [7:0]    pres_st [0:N];

    logic [N:1]    vld_reg;
    logic [N:1]    bad_reg;
    logic [V-1:0]  val_reg  [1:N];
    logic [31:0]   dig_reg  [1:N];
    logic [7:0]    pres_reg [1:N];

    assign vld_st[0]  = in_vld;
    assign bad_st[0]  = in_bad;
    assign val_st[0]  = in_value;
    assign dig_st[0]  = '0;
    assign pres_st[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [V+31:0] prod;
        logic [V-1:0]  quo;
        logic [3:0]    dig;
        logic          show;
        logic [31:0]   dig_next;
        logic [7:0]    pres_next;

        always_comb begin
            // v / 10 by reciprocal, exact below 2^32
            prod = (V+32)'(val_st[k]) * (V+32)'(32'hCCCC_CCCD);
            quo  = V'(prod >> 35);
            dig  = 4'(val_st[k] - V'((quo << 3) + (quo << 1)));
            show = (k == 0) || (val_st[k] != '0);
            dig_next  = dig_st[k];
            pres_next = pres_st[k];
            if (show) begin
                dig_next[4*k +: 4] = dig;
                pres_next[k]       = 1'b1;
            end
            if (k == N - 1 && bad_st[k]) begin
                dig_next  = ERR_DIGITS;
                pres_next = ERR_PRESENT;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_st[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                bad_reg[k+1]  <= bad_st[k];
                val_reg[k+1]  <= quo;
                dig_reg[k+1]  <= dig_next;
                pres_reg[k+1] <= pres_next;
            end
        end

        assign vld_st[k+1]  = vld_reg[k+1];
        assign bad_st[k+1]  = bad_reg[k+1];
        assign val_st[k+1]  = val_reg[k+1];
        assign dig_st[k+1]  = dig_reg[k+1];
        assign pres_st[k+1] = pres_reg[k+1];
    end

    assign out_vld                 = vld_st[N];
    assign out_data.answer_digits  = dig_st[N];
    assign out_data.answer_present = pres_st[N];
    assign out_data.error          = bad_st[N];

endmodule

// File: rtl/decimal_digit_calculator_alu_core.sv
// Eight-digit decimal calculator ALU, pipelined top level
//
// Input channel s_*: one beat carries the operation (add, subtract,
// multiply, divide) and two decimal operands with per-digit presence bits.
// Output channel m_*: one beat per input beat, in order, with the answer
// digits, their presence bits and an error flag (overflow, negative
// difference, divide by zero show the error pattern).
// Path from accept to m_valid: operand decode and arithmetic, the
// bit-per-stage divider, the quotient pick, then digit conversion.
// Every operation takes the full path.
// Throughput: one beat per cycle while the output is not stalled; the
// divider and digit pipelines are fully staged, so a new beat may enter each such cycle.
// Reset (aresetn low, synchronous) empties the pipeline; beats in flight
// at that time are discarded.
// When the receiver holds m_ready low with m_valid high, the whole
// pipeline freezes and s_ready drops; nothing is dropped or repeated.
module decimal_digit_calculator_alu_core #(
    parameter longint unsigned MAX_VALUE = 99999999,
    parameter int              DIGITS    = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ddcalu_pkg::in_t     s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ddcalu_pkg::out_t    m_data
);
    `include "decimal_digit_calculator_alu_core_macros.svh"

    localparam int W = ddcalu_pkg::OPD_W;
    localparam int V = ddcalu_pkg::VAL_W;
    localparam int R = ddcalu_pkg::RAW_W;
    localparam logic [V-1:0] LIMIT = V'(ddcalu_pkg::disp_limit(DIGITS, MAX_VALUE));
    localparam logic [7:0]   POS_MASK = 8'((1 << DIGITS) - 1);
    localparam logic [7:0]   ERR_PRES = 8'h07 & POS_MASK;
    localparam logic [31:0]  ERR_DIG  = 32'h0000_0E0F &
        {{20{1'b0}}, {4{ERR_PRES[2]}}, {4{ERR_PRES[1]}}, {4{ERR_PRES[0]}}};

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: operand values
    logic [W-1:0] a_next, b_next;
    logic         s1_vld_reg;
    logic [1:0]   s1_op_reg;
    logic [W-1:0] s1_a_reg, s1_b_reg;

    always_comb begin
        a_next = '0;
        b_next = '0;
        for (int i = 0; i < ddcalu_pkg::NUM_POS; i++) begin
            if (i < DIGITS && s_data.a_present[i]) begin
                a_next = W'(a_next + W'(s_data.a_digits[4*i +: 4]) * ddcalu_pkg::pow10(i));
            end
            if (i < DIGITS && s_data.b_present[i]) begin
                b_next = W'(b_next + W'(s_data.b_digits[4*i +: 4]) * ddcalu_pkg::pow10(i));
            end
        end
    end

    // stage 2: add, subtract, multiply
    logic [R-1:0] raw_next;
    logic         neg_next;
    logic         s2_vld_reg;
    logic [1:0]   s2_op_reg;
    logic [W-1:0] s2_a_reg, s2_b_reg;
    logic [R-1:0] s2_raw_reg;
    logic         s2_neg_reg;

    always_comb begin
        raw_next = '0;
        neg_next = 1'b0;
        case (ddcalu_pkg::op_t'(s1_op_reg))
            ddcalu_pkg::OP_ADD: raw_next = R'(s1_a_reg) + R'(s1_b_reg);
            ddcalu_pkg::OP_SUB: begin
                neg_next = (s1_a_reg < s1_b_reg);
                raw_next = R'(W'(s1_a_reg - s1_b_reg));
            end
            ddcalu_pkg::OP_MUL: raw_next = R'(s1_a_reg) * R'(s1_b_reg);
            default:            raw_next = '0;
        endcase
    end

    // stage 3: range check, feed divider
    ddcalu_pkg::side_t side_next;
    logic              s3_vld_reg;
    logic [W-1:0]      s3_a_reg, s3_b_reg;
    ddcalu_pkg::side_t s3_side_reg;

    always_comb begin
        side_next.is_div = (ddcalu_pkg::op_t'(s2_op_reg) == ddcalu_pkg::OP_DIV);
        side_next.b_zero = (s2_b_reg == '0);
        side_next.bad    = s2_neg_reg || (!side_next.is_div && s2_raw_reg > R'(LIMIT));
        side_next.value  = V'(s2_raw_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= s_data.operation;
            s1_a_reg    <= a_next;
            s1_b_reg    <= b_next;
            s2_op_reg   <= s1_op_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_raw_reg  <= raw_next;
            s2_neg_reg  <= neg_next;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_side_reg <= side_next;
        end
    end

    logic              div_vld;
    logic [W-1:0]      div_quo;
    ddcalu_pkg::side_t div_side;

    ddcalu_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_vld      (s3_vld_reg),
        .in_dividend (s3_a_reg),
        .in_divisor  (s3_b_reg),
        .in_side     (s3_side_reg),
        .out_vld     (div_vld),
        .out_quo     (div_quo),
        .out_side    (div_side)
    );

    // stage 4: pick quotient or earlier result
    logic         s4_vld_reg;
    logic         s4_bad_reg;
    logic [V-1:0] s4_val_reg;
    logic         bad_next;
    logic [V-1:0] val_next;

    always_comb begin
        if (div_side.is_div) begin
            bad_next = div_side.b_zero || (div_quo > W'(LIMIT));
            val_next = V'(div_quo);
        end else begin
            bad_next = div_side.bad;
            val_next = div_side.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_bad_reg <= bad_next;
            s4_val_reg <= val_next;
        end
    end

    ddcalu_bcd #(
        .ERR_DIGITS  (ERR_DIG),
        .ERR_PRESENT (ERR_PRES)
    ) u_bcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_bad   (s4_bad_reg),
        .in_value (s4_val_reg),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

    `DDC_ASSERT(a_err_pattern, m_valid && m_data.error |-> m_data.answer_present == ERR_PRES, "error beat without error pattern")
    `DDC_ASSERT(a_lead_digit, m_valid && !m_data.error |-> m_data.answer_present[0], "answer missing position 0")
    `DDC_ASSERT(a_no_gaps, m_valid |-> ((m_data.answer_present & 8'(m_data.answer_present + 8'd1)) == 8'd0), "blank position below a shown digit")
    `DDC_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_valid, "output valid right after reset")

endmodule

// File: bench/testbench.sv
// Self-checking bench for the eight-digit decimal calculator ALU
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY   = 40;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 600;
    localparam int IN_W      = $bits(ddcalu_pkg::in_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ddcalu_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ddcalu_pkg::out_t m_data;

    ddcalu_pkg::in_t  pending_ops[$];
    ddcalu_pkg::out_t answers_due[$];
    int   mismatches = 0;
    int   beats_out = 0;
    int   errors_seen = 0;
    int   wdog = 0;
    bit   quiet = 0;       // no idling in the closing stretch
    bit   hold_send = 0;
    int   s_gap = 0;
    int   m_gap = 0;

    decimal_digit_calculator_alu_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint unsigned operand_sum(logic [31:0] dg, logic [7:0] pr);
        longint unsigned v;
        longint unsigned w;
        v = 0;
        w = 1;
        for (int i = 0; i < 8; i++) begin
            if (pr[i]) v += longint'(dg[4*i +: 4]) * w;
            w *= 10;
        end
        return v;
    endfunction

    function automatic ddcalu_pkg::out_t calc_answer(ddcalu_pkg::in_t it);
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        bit bad;
        ddcalu_pkg::out_t r;
        a = operand_sum(it.a_digits, it.a_present);
        b = operand_sum(it.b_digits, it.b_present);
        v = 0;
        bad = 0;
        r = '0;
        case (ddcalu_pkg::op_t'(it.operation))
            ddcalu_pkg::OP_ADD: v = a + b;
            ddcalu_pkg::OP_SUB: if (a < b) bad = 1; else v = a - b;
            ddcalu_pkg::OP_MUL: v = a * b;
            default: if (b == 0) bad = 1; else v = a / b;
        endcase
        if (!bad && v > 64'd99999999) bad = 1;
        if (bad) begin
            r.answer_digits = 32'h0000_0E0F;
            r.answer_present = 8'h07;
            r.error = 1'b1;
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (i == 0 || v != 0) begin
                    r.answer_digits[4*i +: 4] = 4'(v % 10);
                    r.answer_present[i] = 1'b1;
                    v /= 10;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_decimal(int n);
        logic [31:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) d[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return d;
    endfunction

    function automatic logic [7:0] low_mask(int n);
        return 8'((16'd1 << n) - 1);
    endfunction

    task automatic queue_op(ddcalu_pkg::op_t op, logic [31:0] ad, logic [7:0] ap,
                            logic [31:0] bd, logic [7:0] bp);
        ddcalu_pkg::in_t it;
        it.operation = op;
        it.a_digits = ad;
        it.a_present = ap;
        it.b_digits = bd;
        it.b_present = bp;
        pending_ops.push_back(it);
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                answers_due.push_back(calc_answer(s_data));
            end
            if (!(s_valid && !s_ready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    s_gap <= $urandom_range(1, 19);
                    s_valid <= 1'b0;
                end else if (!hold_send && pending_ops.size() > 0) begin
                    s_data <= pending_ops.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        ddcalu_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (m_data.error) errors_seen++;
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", m_data);
                end else begin
                    want = answers_due.pop_front();
                    if (m_data.answer_digits !== want.answer_digits ||
                        m_data.answer_present !== want.answer_present ||
                        m_data.error !== want.error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%h/%b got %h/%h/%b",
                                     want.answer_digits, want.answer_present, want.error,
                                     m_data.answer_digits, m_data.answer_present,
                                     m_data.error);
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                m_gap <= $urandom_range(1, 19);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) wdog <= 0;
            else wdog <= wdog + 1;
        end
    end

    always @(posedge aclk) begin
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n;
        int m;
        int k;
        // directed: extremes, each op, errors, codes above nine, blanks
        queue_op(ddcalu_pkg::OP_ADD, 32'h0, 8'h00, 32'h0, 8'h00);
        queue_op(ddcalu_pkg::OP_ADD, 32'h9999_9999, 8'hFF, 32'h0, 8'h00);
        queue_op(ddcalu_pkg::OP_ADD, 32'h9999_9999, 8'hFF, 32'h1, 8'h01);
        queue_op(ddcalu_pkg::OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        queue_op(ddcalu_pkg::OP_ADD, 32'hFFFF_FFFF, 8'h00, 32'h0000_000F, 8'h01);
        queue_op(ddcalu_pkg::OP_SUB, 32'h0000_0005, 8'h01, 32'h0000_0007, 8'h01);
        queue_op(ddcalu_pkg::OP_SUB, 32'h0012_3456, 8'h3F, 32'h0012_3456, 8'h3F);
        queue_op(ddcalu_pkg::OP_SUB, 32'h9999_9999, 8'hFF, 32'h0000_0001, 8'h01);
        queue_op(ddcalu_pkg::OP_SUB, 32'h0000_0000, 8'h01, 32'hAAAA_AAAA, 8'hAA);
        queue_op(ddcalu_pkg::OP_MUL, 32'h0000_9999, 8'h0F, 32'h0000_9999, 8'h0F);
        queue_op(ddcalu_pkg::OP_MUL, 32'h0001_0000, 8'h1F, 32'h0000_1000, 8'h0F);
        queue_op(ddcalu_pkg::OP_MUL, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        queue_op(ddcalu_pkg::OP_MUL, 32'h9999_9999, 8'hFF, 32'h0, 8'h01);
        queue_op(ddcalu_pkg::OP_MUL, 32'h0000_1111, 8'h0F, 32'h0000_9001, 8'h0F);
        queue_op(ddcalu_pkg::OP_DIV, 32'h0000_0042, 8'h03, 32'h0, 8'h00);
        queue_op(ddcalu_pkg::OP_DIV, 32'h0000_0042, 8'h03, 32'h5555_5555, 8'h00);
        queue_op(ddcalu_pkg::OP_DIV, 32'h9999_9999, 8'hFF, 32'h0000_0001, 8'h01);
        queue_op(ddcalu_pkg::OP_DIV, 32'h0000_0007, 8'h01, 32'h0000_0009, 8'h01);
        queue_op(ddcalu_pkg::OP_DIV, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0003, 8'h01);
        queue_op(ddcalu_pkg::OP_DIV, 32'h0000_0100, 8'h07, 32'h0000_0007, 8'h01);
        queue_op(ddcalu_pkg::OP_ADD, 32'h0000_00B0, 8'h02, 32'h0000_000C, 8'h01);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++) begin
            ddcalu_pkg::in_t it;
            k = $urandom_range(0, 9);
            if (k < 2) begin
                // noise: arbitrary codes and presence bits
                it = IN_W'({$urandom, $urandom, $urandom});
            end else begin
                n = $urandom_range(0, 8);
                m = (k < 5) ? $urandom_range(0, 4) : $urandom_range(0, 8);
                it.operation = 2'($urandom_range(0, 3));
                it.a_digits = rand_decimal(n) | (k == 2 ? $urandom : 32'h0);
                it.a_present = low_mask(n);
                it.b_digits = rand_decimal(m);
                it.b_present = low_mask(m);
                if (k == 3) it.b_present = 8'($urandom);
            end
            pending_ops.push_back(it);
            if (i == N_RANDOM / 2) begin
                // drain fully once before carrying on
                while (pending_ops.size() > 0 || s_valid) @(negedge aclk);
                hold_send = 1;
                while (answers_due.size() > 0) @(negedge aclk);
                hold_send = 0;
            end
        end
        while (pending_ops.size() > 100) @(negedge aclk);
        quiet = 1;
        while (pending_ops.size() > 0 || s_valid) @(negedge aclk);
        while (answers_due.size() > 0) @(negedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("%0d answers checked, %0d of them error patterns, %0d mismatches",
                 beats_out, errors_seen, mismatches);
        $display("covered add, subtract, multiply, divide with stalls on both sides");
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
